>>> rtl/core/i2cms_pkg.sv
// ============================================================================
// i2cms_pkg
// Shared types, constants and the control store of the I2C bit sequencer.
// ============================================================================
package i2cms_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = $clog2(BITS_PER_BYTE);
    localparam int PC_W          = 5;
    localparam int PHASE_W       = 16;
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 3;

    localparam logic [PHASE_W-1:0] PHASE_CYCLES_RST = 16'd250;

    // register index
    localparam logic REG_PHASE_CYCLES = 1'b0;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_SACK  = 3'd4,
        OP_RACK  = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        SCL_KEEP = 2'd0,
        SCL_LOW  = 2'd1,
        SCL_HIGH = 2'd2
    } t_scl_op;

    typedef enum logic [2:0] {
        SDA_KEEP  = 3'd0,
        SDA_LOW   = 3'd1,
        SDA_HIGH  = 3'd2,
        SDA_TXBIT = 3'd3,
        SDA_ACK   = 3'd4
    } t_sda_op;

    // one control word per phase
    typedef struct packed {
        t_scl_op          scl_op;
        t_sda_op          sda_op;
        logic             sample;   // phase samples the data line
        logic             bit_end;  // closes one bit: shift, count, loop
        logic             fin;      // unconditional last phase
        logic             rx_out;   // show the read byte on the last phase
        logic             ack_out;  // show the sampled ack
        logic [PC_W-1:0]  loop_pc;  // target while bits remain
    } t_uop;

    typedef struct packed {
        logic  load;   // command taken, latch its fields
        logic  exec;   // run the current control word this cycle
        logic  last;   // this phase closes the command
        t_uop  uop;
    } t_dp_ctl;

    // entry points
    localparam logic [PC_W-1:0] PC_START = 5'd0;
    localparam logic [PC_W-1:0] PC_STOP  = 5'd4;
    localparam logic [PC_W-1:0] PC_WRITE = 5'd7;
    localparam logic [PC_W-1:0] PC_READ  = 5'd10;
    localparam logic [PC_W-1:0] PC_SACK  = 5'd14;
    localparam logic [PC_W-1:0] PC_RACK  = 5'd17;

    localparam logic [PC_W-1:0] PC_NONE = '0;

    function automatic t_uop mk_uop(t_scl_op scl, t_sda_op sda, logic smp,
                                    logic bend, logic fin, logic rxo,
                                    logic acko, logic [PC_W-1:0] lpc);
        t_uop u;
        u.scl_op  = scl;
        u.sda_op  = sda;
        u.sample  = smp;
        u.bit_end = bend;
        u.fin     = fin;
        u.rx_out  = rxo;
        u.ack_out = acko;
        u.loop_pc = lpc;
        return u;
    endfunction

    // control store
    function automatic t_uop uop_rom(logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            // start
            5'd0:  u = mk_uop(SCL_KEEP, SDA_HIGH,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd1:  u = mk_uop(SCL_HIGH, SDA_KEEP,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd2:  u = mk_uop(SCL_KEEP, SDA_LOW,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd3:  u = mk_uop(SCL_LOW,  SDA_KEEP,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, PC_NONE);
            // stop
            5'd4:  u = mk_uop(SCL_KEEP, SDA_LOW,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd5:  u = mk_uop(SCL_HIGH, SDA_KEEP,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd6:  u = mk_uop(SCL_KEEP, SDA_HIGH,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, PC_NONE);
            // write byte
            5'd7:  u = mk_uop(SCL_KEEP, SDA_TXBIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd8:  u = mk_uop(SCL_HIGH, SDA_KEEP,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd9:  u = mk_uop(SCL_LOW,  SDA_KEEP,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, PC_WRITE);
            // read byte
            5'd10: u = mk_uop(SCL_KEEP, SDA_HIGH,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd11: u = mk_uop(SCL_HIGH, SDA_KEEP,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd12: u = mk_uop(SCL_KEEP, SDA_KEEP,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd13: u = mk_uop(SCL_LOW,  SDA_KEEP,  1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 5'd11);
            // send ack
            5'd14: u = mk_uop(SCL_KEEP, SDA_ACK,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd15: u = mk_uop(SCL_HIGH, SDA_KEEP,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd16: u = mk_uop(SCL_LOW,  SDA_KEEP,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, PC_NONE);
            // read ack
            5'd17: u = mk_uop(SCL_KEEP, SDA_HIGH,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd18: u = mk_uop(SCL_HIGH, SDA_KEEP,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd19: u = mk_uop(SCL_KEEP, SDA_KEEP,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_NONE);
            5'd20: u = mk_uop(SCL_LOW,  SDA_KEEP,  1'b0, 1'b0, 1'b1, 1'b0, 1'b1, PC_NONE);
            // unused words end the command
            default: u = mk_uop(SCL_KEEP, SDA_KEEP, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, PC_NONE);
        endcase
        return u;
    endfunction

endpackage

>>> rtl/core/i2cms_if.sv
// ============================================================================
// i2cms_if
// Command and phase-result channels of the I2C bit sequencer.
// ============================================================================
interface i2cms_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic [7:0] slave_bits;
    logic       slave_ack;

    modport source (output valid, opcode, tx_byte, ack_level, slave_bits, slave_ack,
                    input ready);
    modport sink   (input valid, opcode, tx_byte, ack_level, slave_bits, slave_ack,
                    output ready);
endinterface

interface i2cms_phase_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sample_phase;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       last;

    modport source (output valid, scl_level, sda_level, sample_phase, rx_byte,
                    ack_seen, last, input ready);
    modport sink   (input valid, scl_level, sda_level, sample_phase, rx_byte,
                    ack_seen, last, output ready);
endinterface

>>> rtl/core/i2cms_seq.sv
// ============================================================================
// i2cms_seq
// Step counter, phase timer and bit counter over the control store.
// ============================================================================
module i2cms_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  logic [2:0]                      i_opcode,
    output logic                            o_cmd_ready,
    input  logic [i2cms_pkg::PHASE_W-1:0]   i_phase_cycles,
    input  logic                            i_out_free,
    output i2cms_pkg::t_dp_ctl              o_ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_seq_state;

    t_seq_state                          r_state, n_state;
    logic [i2cms_pkg::PC_W-1:0]          r_pc, n_pc;
    logic [i2cms_pkg::BIT_W-1:0]         r_bit, n_bit;
    logic [i2cms_pkg::PHASE_W-1:0]       r_timer, n_timer;

    i2cms_pkg::t_uop                     uop;
    logic                                load;
    logic                                phase_done;
    logic                                exec;
    logic                                bit_done;
    logic                                last;
    logic                                op_ok;
    logic [i2cms_pkg::PC_W-1:0]          entry_pc;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign load        = i_cmd_valid && o_cmd_ready;
    assign uop         = i2cms_pkg::uop_rom(r_pc);

    // phase ends once timer + 1 reaches phase_cycles (a zero setting acts as a setting of one)
    assign phase_done = ({1'b0, r_timer} + 17'd1) >= {1'b0, i_phase_cycles};
    assign exec       = (r_state == ST_RUN) && phase_done && i_out_free;
    assign bit_done   = (r_bit == i2cms_pkg::BIT_W'(i2cms_pkg::BITS_PER_BYTE - 1));
    assign last       = uop.fin || (uop.bit_end && bit_done);

    always_comb begin
        op_ok    = 1'b1;
        entry_pc = i2cms_pkg::PC_NONE;
        unique case (i_opcode)
            i2cms_pkg::OP_START: entry_pc = i2cms_pkg::PC_START;
            i2cms_pkg::OP_STOP:  entry_pc = i2cms_pkg::PC_STOP;
            i2cms_pkg::OP_WRITE: entry_pc = i2cms_pkg::PC_WRITE;
            i2cms_pkg::OP_READ:  entry_pc = i2cms_pkg::PC_READ;
            i2cms_pkg::OP_SACK:  entry_pc = i2cms_pkg::PC_SACK;
            i2cms_pkg::OP_RACK:  entry_pc = i2cms_pkg::PC_RACK;
            default:             op_ok    = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_bit   = r_bit;
        n_timer = r_timer;
        unique case (r_state)
            ST_IDLE: begin
                if (load && op_ok) begin
                    n_state = ST_RUN;
                    n_pc    = entry_pc;
                    n_bit   = '0;
                    n_timer = '0;
                end
            end
            ST_RUN: begin
                if (!phase_done) begin
                    n_timer = r_timer + 1'b1;
                end else if (i_out_free) begin
                    n_timer = '0;
                    if (uop.bit_end && !bit_done) begin
                        n_pc  = uop.loop_pc;
                        n_bit = r_bit + 1'b1;
                    end else if (last) begin
                        n_state = ST_IDLE;
                        n_bit   = '0;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_bit   <= '0;
            r_timer <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_bit   <= n_bit;
            r_timer <= n_timer;
        end
    end

    assign o_ctl.load = load;
    assign o_ctl.exec = exec;
    assign o_ctl.last = last;
    assign o_ctl.uop  = uop;

    a_exec_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |-> (i_out_free && r_state == ST_RUN))
        else $error("phase executed without output room");

    a_idle_bit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_bit == '0))
        else $error("bit counter not cleared in idle");

    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && last) |=> (r_state == ST_IDLE))
        else $error("sequencer kept running after last phase");

    a_loop_only_on_bit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && !uop.bit_end && !last) |=> (r_pc == $past(r_pc) + 1'b1))
        else $error("jump taken outside a bit end");

endmodule

>>> rtl/core/i2cms_dp.sv
// ============================================================================
// i2cms_dp
// Line levels, byte shifters and the phase-result output register.
// ============================================================================
module i2cms_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2cms_pkg::t_dp_ctl  i_ctl,
    input  logic [2:0]          i_opcode,
    input  logic [7:0]          i_tx_byte,
    input  logic                i_ack_level,
    input  logic [7:0]          i_slave_bits,
    input  logic                i_slave_ack,
    output logic                o_out_free,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_scl_level,
    output logic                o_sda_level,
    output logic                o_sample_phase,
    output logic [7:0]          o_rx_byte,
    output logic                o_ack_seen,
    output logic                o_last
);

    logic       r_scl, r_sda, n_scl, n_sda;
    logic [7:0] r_src;      // write byte or slave bits, MSB at the top
    logic [7:0] r_rx;       // assembled read byte
    logic       r_ackl;
    logic       r_sack;
    logic       r_valid;

    assign o_out_free = !r_valid || i_ready;
    assign o_valid    = r_valid;

    always_comb begin
        unique case (i_ctl.uop.scl_op)
            i2cms_pkg::SCL_LOW:  n_scl = 1'b0;
            i2cms_pkg::SCL_HIGH: n_scl = 1'b1;
            default:             n_scl = r_scl;
        endcase
        unique case (i_ctl.uop.sda_op)
            i2cms_pkg::SDA_LOW:   n_sda = 1'b0;
            i2cms_pkg::SDA_HIGH:  n_sda = 1'b1;
            i2cms_pkg::SDA_TXBIT: n_sda = r_src[7];
            i2cms_pkg::SDA_ACK:   n_sda = r_ackl;
            default:              n_sda = r_sda;
        endcase
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            if (i_ctl.exec) begin
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_src  <= (i_opcode == i2cms_pkg::OP_READ) ? i_slave_bits : i_tx_byte;
            r_ackl <= i_ack_level;
            r_sack <= i_slave_ack;
        end else if (i_ctl.exec && i_ctl.uop.bit_end) begin
            r_src <= {r_src[6:0], 1'b0};
        end
        if (i_ctl.exec && i_ctl.uop.sample) begin
            r_rx <= {r_rx[6:0], r_src[7]};
        end
        if (i_ctl.exec) begin
            o_scl_level    <= n_scl;
            o_sda_level    <= n_sda;
            o_sample_phase <= i_ctl.uop.sample;
            o_last         <= i_ctl.last;
            o_rx_byte      <= (i_ctl.uop.rx_out && i_ctl.last) ? r_rx : 8'd0;
            o_ack_seen     <= i_ctl.uop.ack_out ? r_sack : 1'b0;
        end
    end

    a_sample_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_sample_phase) |-> !o_last)
        else $error("sample phase flagged as last");

    a_sample_keeps_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && i_ctl.uop.sample) |-> (n_scl == r_scl && n_sda == r_sda))
        else $error("line drive moved in a sample phase");

    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_last) |-> (o_rx_byte == 8'd0 && !o_ack_seen))
        else $error("read status shown before last phase");

endmodule

>>> rtl/core/i2c_master_bit_sequencer_top.sv
// ============================================================================
// i2c_master_bit_sequencer_top
// I2C master primitive engine: one bus command in, a paced run of line
// phases out, driven by a microcoded step sequencer.
// ============================================================================
//
//  channel   dir  handshake           payload
//  --------  ---  ------------------  -------------------------------------------
//  i_cmd     in   valid / ready       opcode, tx_byte, ack_level, slave_bits,
//                                     slave_ack
//  o_phase   out  valid / ready       scl_level, sda_level, sample_phase,
//                                     rx_byte, ack_seen, last
//  apb       in   psel/penable/pready phase_cycles at byte address 0
//
//  Each phase result is paced by the phase timer against phase_cycles;
//  the phases per command are: start 4, stop 3, write 24, read 25,
//  send ack 3, read ack 4 phases. Opcodes 6 and 7 are taken and dropped.
//  Reset (synchronous, active low) releases both lines high, empties the
//  output register and sets phase_cycles to 250.
//  A stalled o_phase freezes the timer at the end of a phase; a new command
//  is taken once the last phase of the previous one sits in the output
//  register.
//
module i2c_master_bit_sequencer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    i2cms_cmd_if.sink                         i_cmd,
    i2cms_phase_if.source                     o_phase,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cms_pkg::APB_AW-1:0]      paddr,
    input  logic [i2cms_pkg::APB_DW-1:0]      pwdata,
    output logic [i2cms_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    logic [i2cms_pkg::PHASE_W-1:0] r_phase_cycles;
    logic                          cfg_wr;
    logic                          reg_hit;
    logic                          out_free;
    logic                          cmd_ready;
    i2cms_pkg::t_dp_ctl            ctl;

    // ---- configuration: register index is paddr[2], low bits are byte lanes
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == i2cms_pkg::REG_PHASE_CYCLES);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? {{(i2cms_pkg::APB_DW - i2cms_pkg::PHASE_W){1'b0}},
                                r_phase_cycles}
                             : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_cycles <= i2cms_pkg::PHASE_CYCLES_RST;
        end else if (cfg_wr) begin
            r_phase_cycles <= pwdata[i2cms_pkg::PHASE_W-1:0];
        end
    end

    // ---- sequencer: step counter over the control store
    i2cms_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_cmd.valid),
        .i_opcode       (i_cmd.opcode),
        .o_cmd_ready    (cmd_ready),
        .i_phase_cycles (r_phase_cycles),
        .i_out_free     (out_free),
        .o_ctl          (ctl)
    );

    assign i_cmd.ready = cmd_ready;

    // ---- datapath: line levels, shifters, output register
    i2cms_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_opcode       (i_cmd.opcode),
        .i_tx_byte      (i_cmd.tx_byte),
        .i_ack_level    (i_cmd.ack_level),
        .i_slave_bits   (i_cmd.slave_bits),
        .i_slave_ack    (i_cmd.slave_ack),
        .o_out_free     (out_free),
        .o_valid        (o_phase.valid),
        .i_ready        (o_phase.ready),
        .o_scl_level    (o_phase.scl_level),
        .o_sda_level    (o_phase.sda_level),
        .o_sample_phase (o_phase.sample_phase),
        .o_rx_byte      (o_phase.rx_byte),
        .o_ack_seen     (o_phase.ack_seen),
        .o_last         (o_phase.last)
    );

endmodule
